@@ rtl/tws_pkg.sv @@
// Shared types and sizes for the three-way quicksort block.
package tws_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // One pending range of the store, both ends inclusive.
  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    range_t data;
  } stack_cmd_t;

  // Result offered by the sequencer to the output register.
  typedef struct packed {
    logic valid;
    key_t key;
    logic last;
    logic ovf;
  } emit_t;

endpackage

@@ rtl/three_way_quicksort.sv @@
// Top level of the batch key sorter: sequencer, range stack and output register.
//
// Keys enter one per cycle into a 64-entry store while the block is loading;
// the key flagged final closes the batch (keys past 64 are dropped and the
// whole batch is then flagged overflow). The batch is sorted in place with a
// three-way partition on a single store with one write and one registered
// read port: each partition pops a range, takes its first key as the pivot,
// then reads every other key, leaves keys equal to the pivot in place, swaps
// the others to the low or high end and pushes the sides that hold two keys
// or more; keys already in order are the slow case. Results then leave one
// at a time, each read from the store before it is offered; in_stall_o stays
// high from the final key until the last result has entered the output register.
module three_way_quicksort (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tws_pkg::KEY_WIDTH-1:0] key_i,
  input  logic                                 final_key_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tws_pkg::KEY_WIDTH-1:0] sorted_key_o,
  output logic                                 end_of_run_o,
  output logic                                 overflow_o
);
  import tws_pkg::*;

  emit_t      emit;
  stack_cmd_t stack_cmd;
  logic       stack_empty;
  range_t     stack_top;
  logic       out_free;

  logic       out_valid_q;
  key_t       out_key_q;
  logic       out_last_q;
  logic       out_ovf_q;

  assign out_free = !out_valid_q || !out_stall_i;

  tws_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_i         (key_t'(key_i)),
    .final_key_i   (final_key_i),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .stack_cmd_o   (stack_cmd),
    .stack_empty_i (stack_empty),
    .stack_top_i   (stack_top)
  );

  tws_range_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stack_cmd),
    .empty_o (stack_empty),
    .top_o   (stack_top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      out_key_q  <= emit.key;
      out_last_q <= emit.last;
      out_ovf_q  <= emit.ovf;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sorted_key_o = $signed(out_key_q);
  assign end_of_run_o = out_last_q;
  assign overflow_o   = out_ovf_q;

endmodule

@@ rtl/tws_range_stack.sv @@
// Stack of pending ranges held in a synchronous memory with a registered top read.
module tws_range_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tws_pkg::stack_cmd_t cmd_i,
  output logic                empty_o,
  output tws_pkg::range_t     top_o
);
  import tws_pkg::*;

  range_t mem [MAX_ITEMS];
  cnt_t   depth_q, depth_d;
  range_t top_q;
  logic   full;

  assign full    = (depth_q == cnt_t'(MAX_ITEMS));
  assign empty_o = (depth_q == '0);
  assign top_o   = top_q;

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.pop && !empty_o) begin
      depth_d = depth_q - cnt_t'(1);
    end else if (cmd_i.push && !full) begin
      depth_d = depth_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.pop && !full) begin
      mem[idx_t'(depth_q)] <= cmd_i.data;
    end
    if (cmd_i.pop && !empty_o) begin
      top_q <= mem[idx_t'(depth_q - cnt_t'(1))];
    end
  end

endmodule

@@ rtl/tws_core.sv @@
// Key store, load logic and the partition/emit sequencer.
module tws_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tws_pkg::key_t       key_i,
  input  logic                final_key_i,
  input  logic                out_free_i,
  output tws_pkg::emit_t      emit_o,
  output tws_pkg::stack_cmd_t stack_cmd_o,
  input  logic                stack_empty_i,
  input  tws_pkg::range_t     stack_top_i
);
  import tws_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_RDI   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_SWL   = 4'd7;
  localparam logic [3:0] S_WRL   = 4'd8;
  localparam logic [3:0] S_SWG   = 4'd9;
  localparam logic [3:0] S_WRG   = 4'd10;
  localparam logic [3:0] S_PUSH1 = 4'd11;
  localparam logic [3:0] S_PUSH2 = 4'd12;
  localparam logic [3:0] S_EMRD  = 4'd13;
  localparam logic [3:0] S_EMLD  = 4'd14;

  logic [3:0] state_q, state_d;
  cnt_t       count_q, count_d;
  logic       dropped_q, dropped_d;
  cnt_t       lt_q, lt_d;
  cnt_t       i_q, i_d;
  cnt_t       gtp_q, gtp_d;     // upper bound plus one
  idx_t       lo_q, lo_d;
  idx_t       hi_q, hi_d;
  idx_t       e_q, e_d;
  key_t       pivot_q, pivot_d;
  key_t       cur_q, cur_d;

  key_t       mem [MAX_ITEMS];
  key_t       rd_q;
  logic       we, re;
  idx_t       wa, ra;
  key_t       wd;

  logic       in_xfer;
  idx_t       gt_idx;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign gt_idx     = idx_t'(gtp_q - cnt_t'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    lt_d        = lt_q;
    i_d         = i_q;
    gtp_d       = gtp_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    e_d         = e_q;
    pivot_d     = pivot_q;
    cur_d       = cur_q;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    re          = 1'b0;
    ra          = '0;
    stack_cmd_o = '0;
    emit_o      = '0;

    unique case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (count_q < cnt_t'(MAX_ITEMS)) begin
            we      = 1'b1;
            wa      = idx_t'(count_q);
            wd      = key_i;
            count_d = count_q + cnt_t'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (final_key_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (count_q > cnt_t'(1)) begin
          stack_cmd_o.push    = 1'b1;
          stack_cmd_o.data.lo = '0;
          stack_cmd_o.data.hi = idx_t'(count_q - cnt_t'(1));
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (stack_empty_i) begin
          e_d     = '0;
          state_d = S_EMRD;
        end else begin
          stack_cmd_o.pop = 1'b1;
          state_d         = S_POPW;
        end
      end
      S_POPW: begin
        lo_d    = stack_top_i.lo;
        hi_d    = stack_top_i.hi;
        lt_d    = cnt_t'(stack_top_i.lo);
        gtp_d   = cnt_t'(stack_top_i.hi) + cnt_t'(1);
        re      = 1'b1;
        ra      = stack_top_i.lo;
        state_d = S_PIV;
      end
      S_PIV: begin
        // first element is the pivot itself: skip its compare
        pivot_d = rd_q;
        i_d     = lt_q + cnt_t'(1);
        state_d = S_RDI;
      end
      S_RDI: begin
        if (i_q < gtp_q) begin
          re      = 1'b1;
          ra      = idx_t'(i_q);
          state_d = S_CMP;
        end else begin
          state_d = S_PUSH1;
        end
      end
      S_CMP: begin
        cur_d = rd_q;
        if (rd_q == pivot_q) begin
          i_d     = i_q + cnt_t'(1);
          state_d = S_RDI;
        end else if ($signed(rd_q) < $signed(pivot_q)) begin
          re      = 1'b1;
          ra      = idx_t'(lt_q);
          state_d = S_SWL;
        end else begin
          re      = 1'b1;
          ra      = gt_idx;
          state_d = S_SWG;
        end
      end
      S_SWL: begin
        we      = 1'b1;
        wa      = idx_t'(lt_q);
        wd      = cur_q;
        state_d = S_WRL;
      end
      S_WRL: begin
        // read data still holds the old low-side key
        we      = 1'b1;
        wa      = idx_t'(i_q);
        wd      = rd_q;
        lt_d    = lt_q + cnt_t'(1);
        i_d     = i_q + cnt_t'(1);
        state_d = S_RDI;
      end
      S_SWG: begin
        we      = 1'b1;
        wa      = idx_t'(i_q);
        wd      = rd_q;
        state_d = S_WRG;
      end
      S_WRG: begin
        we      = 1'b1;
        wa      = gt_idx;
        wd      = cur_q;
        gtp_d   = gtp_q - cnt_t'(1);
        state_d = S_RDI;
      end
      S_PUSH1: begin
        if (lt_q > cnt_t'(lo_q) + cnt_t'(1)) begin
          stack_cmd_o.push    = 1'b1;
          stack_cmd_o.data.lo = lo_q;
          stack_cmd_o.data.hi = idx_t'(lt_q - cnt_t'(1));
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        if (cnt_t'(hi_q) > gtp_q) begin
          stack_cmd_o.push    = 1'b1;
          stack_cmd_o.data.lo = idx_t'(gtp_q);
          stack_cmd_o.data.hi = hi_q;
        end
        state_d = S_POP;
      end
      S_EMRD: begin
        re      = 1'b1;
        ra      = e_q;
        state_d = S_EMLD;
      end
      S_EMLD: begin
        emit_o.valid = 1'b1;
        emit_o.key   = rd_q;
        emit_o.last  = (e_q == idx_t'(count_q - cnt_t'(1)));
        emit_o.ovf   = dropped_q;
        if (out_free_i) begin
          if (emit_o.last) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = S_LOAD;
          end else begin
            e_d     = e_q + idx_t'(1);
            state_d = S_EMRD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      lt_q      <= '0;
      i_q       <= '0;
      gtp_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      e_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      lt_q      <= lt_d;
      i_q       <= i_d;
      gtp_q     <= gtp_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      e_q       <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pivot_q <= pivot_d;
    cur_q   <= cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

endmodule

@@ rtl/tws_checker.sv @@
// Port-level checks for the sorter, bound to the top level.
module tws_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 final_key_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [tws_pkg::KEY_WIDTH-1:0] sorted_key_o,
  input logic                                 end_of_run_o,
  input logic                                 overflow_o
);
  import tws_pkg::*;

  logic       in_xfer, out_xfer;
  logic       in_run_q;
  key_t       prev_key_q;
  logic       prev_ovf_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // track the previous transfer of the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q   <= 1'b0;
      prev_key_q <= '0;
      prev_ovf_q <= 1'b0;
    end else if (out_xfer) begin
      in_run_q   <= !end_of_run_o;
      prev_key_q <= key_t'(sorted_key_o);
      prev_ovf_q <= overflow_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_key_o)
      && $stable(end_of_run_o) && $stable(overflow_o))
    else $error("stalled result changed");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && in_run_q |-> sorted_key_o >= $signed(prev_key_q))
    else $error("results out of order");

  a_ovf_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && in_run_q |-> overflow_o == prev_ovf_q)
    else $error("overflow flag changed within a run");

  a_final_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && final_key_i |=> in_stall_o)
    else $error("input taken while sorting");

endmodule

bind three_way_quicksort tws_checker u_tws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .final_key_i  (final_key_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sorted_key_o (sorted_key_o),
  .end_of_run_o (end_of_run_o),
  .overflow_o   (overflow_o)
);

@@ verif/three_way_quicksort_check.sv @@
// Scoreboard for the batch key sorter: tracks batches, predicts sorted output, compares.
`timescale 1ns / 100ps
module three_way_quicksort_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  tws_pkg::key_t key_i,
  input  logic          final_key_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  tws_pkg::key_t sorted_key_i,
  input  logic          end_of_run_i,
  input  logic          overflow_i,
  output int            fail_count_o,
  output int            pending_o
);
  import tws_pkg::*;

  typedef struct packed {
    key_t key;
    logic last;
    logic ovf;
  } sorted_rec_t;

  sorted_rec_t sorted_q[$];
  key_t        batch_keys[MAX_ITEMS];
  int          batch_len;
  logic        batch_dropped;

  always @(posedge clk_i or negedge rst_ni) begin : track
    key_t        ordered[MAX_ITEMS];
    key_t        k;
    sorted_rec_t want;
    int          i;
    int          j;
    if (!rst_ni) begin
      sorted_q.delete();
      batch_len     = 0;
      batch_dropped = 1'b0;
      fail_count_o  = 0;
    end else begin
      // Check the result transfer against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected result, sorted_key %0d end_of_run %b overflow %b",
                   $time, $signed(sorted_key_i), end_of_run_i, overflow_i);
          fail_count_o++;
        end else begin
          want = sorted_q.pop_front();
          if (sorted_key_i !== want.key) begin
            $display("%0t: sorted_key expected %0d actual %0d",
                     $time, $signed(want.key), $signed(sorted_key_i));
            fail_count_o++;
          end
          if (end_of_run_i !== want.last) begin
            $display("%0t: end_of_run expected %b actual %b", $time, want.last, end_of_run_i);
            fail_count_o++;
          end
          if (overflow_i !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        // Drop keys past capacity, but remember it for the whole batch.
        if (batch_len < MAX_ITEMS) begin
          batch_keys[batch_len] = key_i;
          batch_len++;
        end else begin
          batch_dropped = 1'b1;
        end
        if (final_key_i) begin
          for (i = 0; i < batch_len; i++) ordered[i] = batch_keys[i];
          for (i = 1; i < batch_len; i++) begin
            k = ordered[i];
            j = i - 1;
            while (j >= 0 && $signed(ordered[j]) > $signed(k)) begin
              ordered[j + 1] = ordered[j];
              j--;
            end
            ordered[j + 1] = k;
          end
          for (i = 0; i < batch_len; i++) begin
            want.key  = ordered[i];
            want.last = (i == batch_len - 1);
            want.ovf  = batch_dropped;
            sorted_q.push_back(want);
          end
          batch_len     = 0;
          batch_dropped = 1'b0;
        end
      end
    end
    pending_o = sorted_q.size();
  end

endmodule

@@ verif/three_way_quicksort_test.sv @@
// Testbench top for the batch key sorter: clock, reset, batch stimulus and verdict.
`timescale 1ns / 100ps
module three_way_quicksort_test;
  import tws_pkg::*;

  localparam int   ITEM_TARGET = 460;
  localparam int   IDLE_LIMIT  = 60000;
  localparam int   DRAIN_WAIT  = 300;
  localparam key_t KEY_MIN     = {1'b1, {(KEY_WIDTH - 1){1'b0}}};
  localparam key_t KEY_MAX     = {1'b0, {(KEY_WIDTH - 1){1'b1}}};

  // Key patterns for one batch.
  typedef enum int {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_CONSTANT,
    PAT_ASCENDING,
    PAT_DESCENDING,
    PAT_EXTREMES,
    PAT_COUNT
  } key_pattern_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  key_t key = '0;
  logic final_key = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  key_t sorted_key;
  logic end_of_run;
  logic overflow;

  int fail_count;
  int pending;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  three_way_quicksort dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .key_i        (key),
    .final_key_i  (final_key),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sorted_key_o (sorted_key),
    .end_of_run_o (end_of_run),
    .overflow_o   (overflow)
  );

  three_way_quicksort_check checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .key_i        (key),
    .final_key_i  (final_key),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .sorted_key_i (sorted_key),
    .end_of_run_i (end_of_run),
    .overflow_i   (overflow),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: switch between free-running, light, heavy and periodic stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 8) < 3);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("three_way_quicksort verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one key and hold it until transfer; insert a gap at the end of a burst.
  task automatic send_key(input key_t k, input logic fin);
    in_valid  <= 1'b1;
    key       <= k;
    final_key <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_batch(input int count, input key_pattern_e pattern);
    key_t base;
    key_t k;
    int   step;
    int   i;
    base = $urandom;
    step = $urandom_range(1, 1 << 20);
    for (i = 0; i < count; i++) begin
      case (pattern)
        PAT_NARROW:     k = $urandom_range(0, 6) - 32'd3;
        PAT_CONSTANT:   k = base;
        PAT_ASCENDING:  k = key_t'((i - 40) * step);
        PAT_DESCENDING: k = key_t'((40 - i) * step);
        PAT_EXTREMES: begin
          case ($urandom_range(0, 4))
            0:       k = KEY_MIN;
            1:       k = KEY_MAX;
            2:       k = '0;
            3:       k = '1;
            default: k = $urandom;
          endcase
        end
        default:        k = $urandom;
      endcase
      send_key(k, i == count - 1);
    end
  endtask

  initial begin
    int sel;
    int count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single key, extremes, all equal, mixed duplicates, both orders.
    send_key(KEY_MIN, 1'b1);
    send_key(KEY_MAX, 1'b0);
    send_key(KEY_MIN, 1'b0);
    send_key('0, 1'b0);
    send_key('1, 1'b0);
    send_key(key_t'(1), 1'b1);
    repeat (3) send_key(key_t'(7), 1'b0);
    send_key(key_t'(7), 1'b1);
    send_key(key_t'(5), 1'b0);
    send_key(key_t'(-5), 1'b0);
    send_key(key_t'(5), 1'b0);
    send_key('0, 1'b0);
    send_key(key_t'(-5), 1'b0);
    send_key(key_t'(5), 1'b1);
    send_key(key_t'(3), 1'b0);
    send_key(key_t'(2), 1'b0);
    send_key(key_t'(1), 1'b0);
    send_key('0, 1'b0);
    send_key('1, 1'b1);
    send_key(key_t'(-2), 1'b0);
    send_key('1, 1'b0);
    send_key('0, 1'b1);

    // A full store, then one whose final key is dropped.
    send_batch(MAX_ITEMS, PAT_RANDOM);
    send_batch(MAX_ITEMS + 1, PAT_NARROW);

    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 65)      count = $urandom_range(1, 12);
      else if (sel < 85) count = $urandom_range(13, MAX_ITEMS - 1);
      else if (sel < 93) count = MAX_ITEMS;
      else               count = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
      if ($urandom_range(0, 9) < 4) send_batch(count, PAT_RANDOM);
      else send_batch(count, key_pattern_e'($urandom_range(0, PAT_COUNT - 1)));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("three_way_quicksort verification clean");
    end else begin
      $display("three_way_quicksort verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tws_pkg.sv
rtl/tws_range_stack.sv
rtl/tws_core.sv
rtl/three_way_quicksort.sv
rtl/tws_checker.sv
verif/three_way_quicksort_check.sv
verif/three_way_quicksort_test.sv
